### rtl/core/ilcu_pkg.sv
`timescale 1ns / 1ps

package ilcu_pkg;

    localparam int DEF_DEPTH     = 4096;
    localparam int DEF_POS_WIDTH = 16;

    // learning gain: unsigned Q2.14
    localparam int              GAIN_W     = 16;
    localparam int              GAIN_FRAC  = 14;
    localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd8192;

    localparam int ITER_W      = 16;
    localparam int SNUM_W      = 13;
    localparam int QUEUE_DEPTH = 4;

    // input command codes
    localparam logic CMD_SAMPLE   = 1'b0;
    localparam logic CMD_END_PASS = 1'b1;

    // width of one work entry passed from the front to the back
    function automatic int ilcu_entry_w(int pos_w, int addr_w);
        return 2 + addr_w + SNUM_W + ITER_W + 6 * pos_w;
    endfunction

endpackage

### rtl/core/ilcu_if.sv
`timescale 1ns / 1ps

interface ilcu_smp_if import ilcu_pkg::*; #(
    parameter int POS_WIDTH = DEF_POS_WIDTH
);
    logic                        valid;
    logic                        ready;
    logic                        command;
    logic signed [POS_WIDTH-1:0] ref_x;
    logic signed [POS_WIDTH-1:0] ref_y;
    logic signed [POS_WIDTH-1:0] ref_z;
    logic signed [POS_WIDTH-1:0] meas_x;
    logic signed [POS_WIDTH-1:0] meas_y;
    logic signed [POS_WIDTH-1:0] meas_z;

    modport source (output valid, command, ref_x, ref_y, ref_z, meas_x, meas_y, meas_z,
                    input ready);
    modport sink   (input valid, command, ref_x, ref_y, ref_z, meas_x, meas_y, meas_z,
                    output ready);
endinterface

interface ilcu_res_if import ilcu_pkg::*; #(
    parameter int POS_WIDTH = DEF_POS_WIDTH
);
    logic                        valid;
    logic                        ready;
    logic signed [POS_WIDTH-1:0] drive_x;
    logic signed [POS_WIDTH-1:0] drive_y;
    logic signed [POS_WIDTH-1:0] drive_z;
    logic signed [POS_WIDTH:0]   err_x;
    logic signed [POS_WIDTH:0]   err_y;
    logic signed [POS_WIDTH:0]   err_z;
    logic [ITER_W-1:0]           pass_number;
    logic [SNUM_W-1:0]           sample_number;
    logic                        overflow;

    modport source (output valid, drive_x, drive_y, drive_z, err_x, err_y, err_z,
                    pass_number, sample_number, overflow, input ready);
    modport sink   (input valid, drive_x, drive_y, drive_z, err_x, err_y, err_z,
                    pass_number, sample_number, overflow, output ready);
endinterface

interface ilcu_cfg_if import ilcu_pkg::*;;
    logic              valid;
    logic              ready;
    logic [GAIN_W-1:0] learning_gain;

    modport source (output valid, learning_gain, input ready);
    modport sink   (input valid, learning_gain, output ready);
endinterface

### rtl/core/ilcu_front.sv
`timescale 1ns / 1ps

module ilcu_front import ilcu_pkg::*; #(
    parameter int DEPTH     = DEF_DEPTH,
    parameter int POS_WIDTH = DEF_POS_WIDTH
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    ilcu_smp_if.sink               i_smp,
    output logic                   o_push,
    output logic [ilcu_entry_w(POS_WIDTH, $clog2(DEPTH))-1:0] o_entry,
    input  logic                   i_full
);
    localparam int AW = $clog2(DEPTH);
    localparam int IW = $clog2(DEPTH + 1);

    typedef struct packed {
        logic                        has_hist;
        logic                        ovf;
        logic [AW-1:0]               addr;
        logic [SNUM_W-1:0]           snum;
        logic [ITER_W-1:0]           pass;
        logic signed [POS_WIDTH-1:0] ref_x;
        logic signed [POS_WIDTH-1:0] ref_y;
        logic signed [POS_WIDTH-1:0] ref_z;
        logic signed [POS_WIDTH-1:0] meas_x;
        logic signed [POS_WIDTH-1:0] meas_y;
        logic signed [POS_WIDTH-1:0] meas_z;
    } t_entry;

    logic [IW-1:0]     r_sample_index, n_sample_index;
    logic [IW-1:0]     r_filled, n_filled;
    logic [ITER_W-1:0] r_pass, n_pass;
    logic              accept;
    logic              ovf;
    t_entry            entry;

    assign i_smp.ready = !i_full;
    assign accept      = i_smp.valid && i_smp.ready;
    assign ovf         = (r_sample_index == IW'(DEPTH));

    always_comb begin
        entry.has_hist = !ovf && (r_sample_index < r_filled);
        entry.ovf      = ovf;
        entry.addr     = r_sample_index[AW-1:0];
        entry.snum     = SNUM_W'(r_sample_index);
        entry.pass     = r_pass;
        entry.ref_x    = i_smp.ref_x;
        entry.ref_y    = i_smp.ref_y;
        entry.ref_z    = i_smp.ref_z;
        entry.meas_x   = i_smp.meas_x;
        entry.meas_y   = i_smp.meas_y;
        entry.meas_z   = i_smp.meas_z;
    end

    assign o_entry = entry;
    assign o_push  = accept && (i_smp.command == CMD_SAMPLE);

    always_comb begin
        n_sample_index = r_sample_index;
        n_filled       = r_filled;
        n_pass         = r_pass;
        if (accept) begin
            if (i_smp.command == CMD_END_PASS) begin
                n_sample_index = '0;
                n_pass         = r_pass + 1'b1;
            end else if (!ovf) begin
                n_sample_index = r_sample_index + 1'b1;
                if (r_sample_index >= r_filled) begin
                    n_filled = r_sample_index + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_index <= '0;
            r_filled       <= '0;
            r_pass         <= '0;
        end else begin
            r_sample_index <= n_sample_index;
            r_filled       <= n_filled;
            r_pass         <= n_pass;
        end
    end

endmodule

### rtl/core/ilcu_fifo.sv
`timescale 1ns / 1ps

module ilcu_fifo import ilcu_pkg::*; #(
    parameter int WIDTH = 8,
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);
    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]    r_count, n_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        case ({do_push, do_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

### rtl/core/ilcu_back.sv
`timescale 1ns / 1ps

module ilcu_back import ilcu_pkg::*; #(
    parameter int DEPTH     = DEF_DEPTH,
    parameter int POS_WIDTH = DEF_POS_WIDTH
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_head_valid,
    input  logic [ilcu_entry_w(POS_WIDTH, $clog2(DEPTH))-1:0] i_head,
    output logic                   o_pop,
    ilcu_cfg_if.sink               i_cfg,
    ilcu_res_if.source             o_res
);
    localparam int AW = $clog2(DEPTH);
    localparam int DW = POS_WIDTH + 1;
    localparam int GW = GAIN_W + 1;
    localparam int PW = DW + GW;
    localparam int SW = PW + 1;
    localparam int MW = 4 * POS_WIDTH;
    localparam logic signed [SW-1:0] RND    = SW'(2 ** (GAIN_FRAC - 1));
    localparam logic signed [SW-1:0] SAT_HI =
        {{(SW - POS_WIDTH + 1){1'b0}}, {(POS_WIDTH - 1){1'b1}}};
    localparam logic signed [SW-1:0] SAT_LO =
        {{(SW - POS_WIDTH + 1){1'b1}}, {(POS_WIDTH - 1){1'b0}}};

    typedef struct packed {
        logic                        has_hist;
        logic                        ovf;
        logic [AW-1:0]               addr;
        logic [SNUM_W-1:0]           snum;
        logic [ITER_W-1:0]           pass;
        logic signed [POS_WIDTH-1:0] ref_x;
        logic signed [POS_WIDTH-1:0] ref_y;
        logic signed [POS_WIDTH-1:0] ref_z;
        logic signed [POS_WIDTH-1:0] meas_x;
        logic signed [POS_WIDTH-1:0] meas_y;
        logic signed [POS_WIDTH-1:0] meas_z;
    } t_entry;

    function automatic logic signed [POS_WIDTH-1:0] learn(
        input logic signed [PW-1:0]        prod,
        input logic signed [POS_WIDTH-1:0] base
    );
        logic signed [SW-1:0] rounded;
        logic signed [SW-1:0] sum;
        rounded = {prod[PW-1], prod} + RND;
        sum     = $signed({{(SW - POS_WIDTH){base[POS_WIDTH-1]}}, base})
                  + (rounded >>> GAIN_FRAC);
        if (sum > SAT_HI) begin
            return SAT_HI[POS_WIDTH-1:0];
        end else if (sum < SAT_LO) begin
            return SAT_LO[POS_WIDTH-1:0];
        end
        return sum[POS_WIDTH-1:0];
    endfunction

    // stored line: {drive_x, drive_y, pos_x, pos_y}
    logic [MW-1:0]               r_mem [DEPTH];
    logic [MW-1:0]               r_rd;
    logic [GAIN_W-1:0]           r_gain;

    t_entry                      head;
    logic                        adv;
    logic                        wr_en;

    logic                        r_b_valid;
    t_entry                      r_b;
    logic                        r_c_valid;
    t_entry                      r_c;
    logic signed [PW-1:0]        r_c_prod_x, r_c_prod_y;
    logic signed [POS_WIDTH-1:0] r_c_drv_x, r_c_drv_y;

    logic                        r_lw_valid;
    logic [AW-1:0]               r_lw_addr;
    logic signed [POS_WIDTH-1:0] r_lw_drv_x, r_lw_drv_y, r_lw_pos_x, r_lw_pos_y;

    logic                        r_o_valid;
    logic signed [POS_WIDTH-1:0] r_o_drive_x, r_o_drive_y, r_o_drive_z;
    logic signed [DW-1:0]        r_o_err_x, r_o_err_y, r_o_err_z;
    logic [ITER_W-1:0]           r_o_pass;
    logic [SNUM_W-1:0]           r_o_snum;
    logic                        r_o_ovf;

    logic                        b_c_hit, b_lw_hit, c_lw_hit;
    logic signed [POS_WIDTH-1:0] b_pos_x, b_pos_y, b_drv_x, b_drv_y;
    logic signed [DW-1:0]        b_diff_x, b_diff_y;
    logic signed [PW-1:0]        b_prod_x, b_prod_y;
    logic signed [POS_WIDTH-1:0] c_base_x, c_base_y, c_drive_x, c_drive_y;

    assign head  = i_head;
    assign adv   = !r_o_valid || o_res.ready;
    assign o_pop = adv && i_head_valid;
    assign wr_en = adv && r_c_valid && !r_c.ovf;

    assign i_cfg.ready = 1'b1;

    // Read stage: the item ahead in C and the last write can both be newer
    // than the memory word that was read.
    always_comb begin
        b_c_hit  = r_c_valid && !r_c.ovf && (r_c.addr == r_b.addr);
        b_lw_hit = r_lw_valid && (r_lw_addr == r_b.addr);
        b_pos_x  = r_rd[2*POS_WIDTH-1 -: POS_WIDTH];
        b_pos_y  = r_rd[POS_WIDTH-1:0];
        b_drv_x  = r_rd[4*POS_WIDTH-1 -: POS_WIDTH];
        b_drv_y  = r_rd[3*POS_WIDTH-1 -: POS_WIDTH];
        if (b_lw_hit) begin
            b_pos_x = r_lw_pos_x;
            b_pos_y = r_lw_pos_y;
            b_drv_x = r_lw_drv_x;
            b_drv_y = r_lw_drv_y;
        end
        if (b_c_hit) begin
            b_pos_x = r_c.meas_x;
            b_pos_y = r_c.meas_y;
        end
        b_diff_x = {r_b.ref_x[POS_WIDTH-1], r_b.ref_x} - {b_pos_x[POS_WIDTH-1], b_pos_x};
        b_diff_y = {r_b.ref_y[POS_WIDTH-1], r_b.ref_y} - {b_pos_y[POS_WIDTH-1], b_pos_y};
        b_prod_x = PW'(b_diff_x) * PW'($signed({1'b0, r_gain}));
        b_prod_y = PW'(b_diff_y) * PW'($signed({1'b0, r_gain}));
    end

    // Update stage: take the drive that the item just ahead wrote, if same index.
    always_comb begin
        c_lw_hit  = r_lw_valid && (r_lw_addr == r_c.addr);
        c_base_x  = c_lw_hit ? r_lw_drv_x : r_c_drv_x;
        c_base_y  = c_lw_hit ? r_lw_drv_y : r_c_drv_y;
        c_drive_x = r_c.has_hist ? learn(r_c_prod_x, c_base_x) : r_c.ref_x;
        c_drive_y = r_c.has_hist ? learn(r_c_prod_y, c_base_y) : r_c.ref_y;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain     <= GAIN_RESET;
            r_b_valid  <= 1'b0;
            r_c_valid  <= 1'b0;
            r_o_valid  <= 1'b0;
            r_lw_valid <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                r_gain <= i_cfg.learning_gain;
            end
            if (adv) begin
                r_b_valid <= i_head_valid;
                r_c_valid <= r_b_valid;
                r_o_valid <= r_c_valid;
            end
            if (wr_en) begin
                r_lw_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_b        <= head;
            r_c        <= r_b;
            r_c_prod_x <= b_prod_x;
            r_c_prod_y <= b_prod_y;
            r_c_drv_x  <= b_drv_x;
            r_c_drv_y  <= b_drv_y;
            r_o_drive_x <= c_drive_x;
            r_o_drive_y <= c_drive_y;
            r_o_drive_z <= r_c.ref_z;
            r_o_err_x   <= {r_c.ref_x[POS_WIDTH-1], r_c.ref_x}
                           - {r_c.meas_x[POS_WIDTH-1], r_c.meas_x};
            r_o_err_y   <= {r_c.ref_y[POS_WIDTH-1], r_c.ref_y}
                           - {r_c.meas_y[POS_WIDTH-1], r_c.meas_y};
            r_o_err_z   <= {r_c.ref_z[POS_WIDTH-1], r_c.ref_z}
                           - {r_c.meas_z[POS_WIDTH-1], r_c.meas_z};
            r_o_pass    <= r_c.pass;
            r_o_snum    <= r_c.snum;
            r_o_ovf     <= r_c.ovf;
        end
        if (wr_en) begin
            r_lw_addr  <= r_c.addr;
            r_lw_drv_x <= c_drive_x;
            r_lw_drv_y <= c_drive_y;
            r_lw_pos_x <= r_c.meas_x;
            r_lw_pos_y <= r_c.meas_y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_rd <= r_mem[head.addr];
        end
        if (wr_en) begin
            r_mem[r_c.addr] <= {c_drive_x, c_drive_y, r_c.meas_x, r_c.meas_y};
        end
    end

    assign o_res.valid         = r_o_valid;
    assign o_res.drive_x       = r_o_drive_x;
    assign o_res.drive_y       = r_o_drive_y;
    assign o_res.drive_z       = r_o_drive_z;
    assign o_res.err_x         = r_o_err_x;
    assign o_res.err_y         = r_o_err_y;
    assign o_res.err_z         = r_o_err_z;
    assign o_res.pass_number   = r_o_pass;
    assign o_res.sample_number = r_o_snum;
    assign o_res.overflow      = r_o_ovf;

endmodule

### rtl/core/iterative_learning_control_update.sv
`timescale 1ns / 1ps
// Channel  Dir  Beat content                                    Handshake
// i_smp    in   command, ref_x/y/z, meas_x/y/z                  valid/ready
// o_res    out  drive_x/y/z, err_x/y/z, pass/sample no, ovf     valid/ready
// i_cfg    in   learning_gain (Q2.14)                           valid/ready, ready always 1
//
// One beat per cycle in and out while the result side keeps taking beats.
// A sample's input beat goes into the queue as it is taken; its result then passes memory read,
// gain multiply, then update/saturate, and is registered before it appears on o_res.
// End-of-pass beats give no result and are handled in the front only.
// Reset (i_rst_n low at an edge) clears counters, queue and gain (to 0.5), not the memory.
// A stall on o_res freezes the back stages; the queue then fills and i_smp.ready drops.

module iterative_learning_control_update import ilcu_pkg::*; #(
    parameter int DEPTH     = DEF_DEPTH,
    parameter int POS_WIDTH = DEF_POS_WIDTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ilcu_smp_if.sink    i_smp,
    ilcu_res_if.source  o_res,
    ilcu_cfg_if.sink    i_cfg
);
    localparam int AW = $clog2(DEPTH);
    localparam int EW = ilcu_entry_w(POS_WIDTH, AW);

    // front -> queue -> back
    logic          push;
    logic [EW-1:0] push_entry;
    logic          q_full;
    logic          pop;
    logic          head_valid;
    logic [EW-1:0] head_entry;

    // Front: accept beats, keep the sample index, fill count and pass count,
    // and tag each sample with whether learned history exists for it.
    ilcu_front #(
        .DEPTH     (DEPTH),
        .POS_WIDTH (POS_WIDTH)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_smp   (i_smp),
        .o_push  (push),
        .o_entry (push_entry),
        .i_full  (q_full)
    );

    // Short queue: lets the front keep taking beats while the result side stalls.
    ilcu_fifo #(
        .WIDTH (EW),
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_entry),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (head_valid),
        .o_data  (head_entry)
    );

    // Back: read history, apply the learning term, write back, register the result.
    ilcu_back #(
        .DEPTH     (DEPTH),
        .POS_WIDTH (POS_WIDTH)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (head_valid),
        .i_head       (head_entry),
        .o_pop        (pop),
        .i_cfg        (i_cfg),
        .o_res        (o_res)
    );

endmodule

### rtl/core/ilcu_checker.sv
`timescale 1ns / 1ps

module ilcu_checker import ilcu_pkg::*; #(
    parameter int DEPTH     = DEF_DEPTH,
    parameter int POS_WIDTH = DEF_POS_WIDTH
) (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_smp_ready,
    input logic                 i_res_valid,
    input logic                 i_res_ready,
    input logic [POS_WIDTH-1:0] i_drive_x,
    input logic [POS_WIDTH-1:0] i_drive_y,
    input logic [POS_WIDTH:0]   i_err_x,
    input logic [ITER_W-1:0]    i_pass,
    input logic [SNUM_W-1:0]    i_snum,
    input logic                 i_ovf
);

    // stalled result beat holds
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid &&
        $stable({i_drive_x, i_drive_y, i_err_x, i_pass, i_snum, i_ovf}))
        else $error("result beat changed while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_res_valid)
        else $error("result valid right after reset");

    a_reset_ready: assert property (@(posedge i_clk)
        !i_rst_n |=> i_smp_ready)
        else $error("input not ready right after reset");

    a_ovf_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_ovf |-> i_snum == SNUM_W'(DEPTH))
        else $error("overflow beat with sample number other than the depth");

endmodule

bind iterative_learning_control_update ilcu_checker #(
    .DEPTH     (DEPTH),
    .POS_WIDTH (POS_WIDTH)
) u_ilcu_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_smp_ready (i_smp.ready),
    .i_res_valid (o_res.valid),
    .i_res_ready (o_res.ready),
    .i_drive_x   (o_res.drive_x),
    .i_drive_y   (o_res.drive_y),
    .i_err_x     (o_res.err_x),
    .i_pass      (o_res.pass_number),
    .i_snum      (o_res.sample_number),
    .i_ovf       (o_res.overflow)
);
